// ===== design/assert_macros.svh =====
// Assertion helpers for the design files; the lookup core includes them.
// Every macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every enabled clock edge.
`define PLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define PLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PLT_ASSERT(lbl, prop, msg)
`define PLT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/plt_pkg.sv =====
package plt_pkg;

  localparam int unsigned PALETTE_ENTRIES_DFLT = 256;

  localparam int unsigned COMP_W   = 6;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned PIXEL_W  = 24;
  localparam int unsigned OFFS_W   = 8;
  localparam int unsigned ENTRY_W  = 3 * COMP_W;

  localparam logic [COMP_W-1:0] COMP_MAX = 6'd63;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_CONVERT = 2'd1,
    ACT_READ    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    FMT_INDEXED   = 3'd0,
    FMT_RGB555    = 3'd1,
    FMT_RGB565    = 3'd2,
    FMT_RGB888    = 3'd3,
    FMT_RGB888_32 = 3'd4
  } fmt_e;

  typedef enum logic {
    REG_PIXEL_FORMAT = 1'b0,
    REG_BRIGHTNESS   = 1'b1
  } cfg_reg_e;

  // One palette entry, red in the lowest bits.
  typedef struct packed {
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] red;
  } rgb_t;

endpackage

// ===== design/plt_ram.sv =====
module plt_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/plt_adj.sv =====
module plt_adj (
  input  plt_pkg::rgb_t                    comp_i,
  input  logic [plt_pkg::OFFS_W-1:0]       offs_i,
  output plt_pkg::rgb_t                    comp_o
);
  import plt_pkg::*;

  // The sum spans -128..190, so bit 8 is set only for a negative result.
  function automatic logic [COMP_W-1:0] clamp_comp(input logic [COMP_W-1:0] c,
                                                   input logic [OFFS_W-1:0] o);
    logic [OFFS_W:0] s;
    s = {3'b000, c} + {o[OFFS_W-1], o};
    if (s[OFFS_W]) begin
      return '0;
    end else if (s[OFFS_W-1:COMP_W] != 2'b00) begin
      return COMP_MAX;
    end else begin
      return s[COMP_W-1:0];
    end
  endfunction

  always_comb begin
    comp_o.red   = clamp_comp(comp_i.red,   offs_i);
    comp_o.green = clamp_comp(comp_i.green, offs_i);
    comp_o.blue  = clamp_comp(comp_i.blue,  offs_i);
  end

endmodule

// ===== design/plt_pack.sv =====
module plt_pack (
  input  plt_pkg::fmt_e                  fmt_i,
  input  logic [plt_pkg::INDEX_W-1:0]    index_i,
  input  plt_pkg::rgb_t                  comp_i,
  output logic [plt_pkg::PIXEL_W-1:0]    pixel_o
);
  import plt_pkg::*;

  always_comb begin
    case (fmt_i)
      FMT_INDEXED: begin
        pixel_o = {16'h0000, index_i};
      end
      FMT_RGB555: begin
        pixel_o = {9'h000, comp_i.red[5:1], comp_i.green[5:1], comp_i.blue[5:1]};
      end
      FMT_RGB565: begin
        pixel_o = {8'h00, comp_i.red[5:1], comp_i.green, comp_i.blue[5:1]};
      end
      FMT_RGB888, FMT_RGB888_32: begin
        pixel_o = {comp_i.red, 2'b00, comp_i.green, 2'b00, comp_i.blue, 2'b00};
      end
      default: begin
        pixel_o = '0;
      end
    endcase
  end

endmodule

// ===== design/palette_color_lookup_core.sv =====
// Palette color lookup core.
// Items arrive on the s_axis channel: tuser carries the action (write entry, convert
// pixel index, read entry) and tdata carries the index and three 6-bit components.
// Every accepted item yields exactly one result transfer on the m_axis channel.
// A write adds the signed brightness offset to each component, clamps to 0..63,
// stores the entry and returns the stored components. A convert returns the packed
// pixel in the configured format. A read returns the stored components.
// An item is registered in the lookup stage, and its entry read from the palette RAM,
// at the edge that accepts it; the result enters the output register once that
// register is free or being drained. Throughput is one item per cycle while the
// receiver keeps up: the palette RAM takes one write and one registered read at
// every edge. When the receiver stalls, the output register and the lookup stage
// fill and s_axis_tready drops; nothing is dropped or repeated.
// Configuration writes on the cfg channel are always taken (cfg_ready_o is high).
// Reset clears a valid bit per palette entry, so every entry reads as zero right
// after reset without a clearing pass; both configuration registers reset to zero.
module palette_color_lookup_core #(
  parameter int unsigned PALETTE_ENTRIES = plt_pkg::PALETTE_ENTRIES_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: index[7:0], red_in[13:8], green_in[19:14], blue_in[25:20], zero pad [31:26].
  input  logic [31:0] s_axis_tdata,
  // tuser: action[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: pixel_value[23:0], red_out[29:24], green_out[35:30], blue_out[41:36],
  // zero pad [47:42].
  output logic [47:0] m_axis_tdata,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import plt_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);

  // Configuration registers.
  fmt_e              fmt_q;
  logic [OFFS_W-1:0] offs_q;

  // Input decode.
  logic                accept;
  action_e             in_act;
  logic [INDEX_W-1:0]  in_idx;
  rgb_t                in_rgb;
  rgb_t                in_adj;
  logic                in_range;
  logic [AddrW-1:0]    in_addr;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_rdata;

  // Per-entry valid bits, cleared at reset.
  logic [PALETTE_ENTRIES-1:0] vld_q;

  // Lookup stage.
  logic               s1_v_q;
  action_e            s1_act_q;
  logic [INDEX_W-1:0] s1_idx_q;
  logic               s1_inr_q;
  logic               s1_hit_q;
  rgb_t               s1_adj_q;

  rgb_t               stored;
  logic [PIXEL_W-1:0] pack_pix;
  rgb_t               res_rgb;
  logic [PIXEL_W-1:0] res_pix;

  // Output register.
  logic               out_v_q;
  logic [PIXEL_W-1:0] out_pix_q;
  rgb_t               out_rgb_q;
  logic               adv;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= FMT_INDEXED;
      offs_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PIXEL_FORMAT: fmt_q  <= fmt_e'(cfg_data_i[2:0]);
        REG_BRIGHTNESS:   offs_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The lookup stage moves on whenever the output register is free or being drained.
  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = !s1_v_q || adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_act       = action_e'(s_axis_tuser);
  assign in_idx       = s_axis_tdata[7:0];
  assign in_rgb.red   = s_axis_tdata[13:8];
  assign in_rgb.green = s_axis_tdata[19:14];
  assign in_rgb.blue  = s_axis_tdata[25:20];

  assign in_range = {1'b0, in_idx} < (INDEX_W+1)'(PALETTE_ENTRIES);
  assign in_addr  = in_idx[AddrW-1:0];
  assign ram_we   = accept && (in_act == ACT_WRITE) && in_range;

  plt_adj u_adj (
    .comp_i (in_rgb),
    .offs_i (offs_q),
    .comp_o (in_adj)
  );

  // The entry is written and read at the accept edge; a write's own result uses the
  // adjusted components, so no forwarding is needed.
  plt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_addr),
    .wdata_i (in_adj),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[in_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_act_q <= in_act;
      s1_idx_q <= in_idx;
      s1_inr_q <= in_range;
      s1_hit_q <= in_range && vld_q[in_addr];
      s1_adj_q <= in_adj;
    end
  end

  // An entry never written since reset reads as zero.
  assign stored = s1_hit_q ? rgb_t'(ram_rdata) : '0;

  plt_pack u_pack (
    .fmt_i   (fmt_q),
    .index_i (s1_idx_q),
    .comp_i  (stored),
    .pixel_o (pack_pix)
  );

  always_comb begin
    res_rgb = '0;
    res_pix = '0;
    case (s1_act_q)
      ACT_WRITE: begin
        res_rgb = s1_inr_q ? s1_adj_q : '0;
      end
      ACT_CONVERT: begin
        res_pix = pack_pix;
      end
      ACT_READ: begin
        res_rgb = stored;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      out_pix_q <= res_pix;
      out_rgb_q <= res_rgb;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b000000, out_rgb_q.blue, out_rgb_q.green, out_rgb_q.red,
                          out_pix_q};

  // Input is held off only while both stages are full and the output is stalled.
  `PLT_ASSERT(a_ready_only_when_full,
              !s_axis_tready |-> (s1_v_q && out_v_q && !m_axis_tready),
              "input stalled while the pipeline has room")

  // A stalled lookup stage keeps its item.
  `PLT_ASSERT_NEXT(a_s1_holds, s1_v_q && !adv, s1_v_q,
                   "lookup stage lost an item while stalled")

  // A stored entry is marked valid from then on.
  `PLT_ASSERT_NEXT(a_write_marks_valid, ram_we, vld_q[$past(in_addr)],
                   "palette write did not set the entry valid bit")

  // A convert reports zero components.
  `PLT_ASSERT_NEXT(a_convert_zero_rgb, s1_v_q && adv && (s1_act_q == ACT_CONVERT),
                   out_rgb_q == '0,
                   "convert result carries nonzero components")

endmodule

// ===== dv/palette_color_lookup_core_tb.sv =====
`timescale 1ns / 1ps

module palette_color_lookup_core_tb;
  import plt_pkg::*;

  // The block is built with its default store size, so every 8-bit index lands in the store.
  localparam int unsigned ENTRIES = PALETTE_ENTRIES_DFLT;

  // Codes that the package leaves out: the spare action and the spare pixel formats.
  localparam logic [1:0] ACT_UNDEFINED = 2'd3;
  localparam logic [2:0] FMT_UNDEFINED_LO = 3'd5;
  localparam logic [2:0] FMT_UNDEFINED_HI = 3'd7;

  localparam int unsigned RANDOM_PHASES = 9;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  // The block holds items only in its lookup stage and output register, which these quiet cycles let drain.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One expected result: the packed pixel and the three reported components.
  typedef struct {
    logic [PIXEL_W-1:0] pixel;
    rgb_t               comps;
  } lookup_t;

  // Mirror of the palette and both registers. It predicts the result of every
  // accepted item and compares the results that leave the block, in order.
  class palette_mirror;
    rgb_t              entries[ENTRIES];
    logic [2:0]        format;
    logic signed [7:0] offset;
    lookup_t           awaited[$];
    int unsigned       mismatches;
    int unsigned       results_seen;

    function new();
      foreach (entries[i]) entries[i] = '0;
      format = FMT_INDEXED;
      offset = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void write_register(cfg_reg_e which, logic [7:0] value);
      if (which == REG_PIXEL_FORMAT) begin
        format = value[2:0];
      end else begin
        offset = value;
      end
    endfunction

    // Adds the signed brightness offset and clamps the sum to the component range.
    function logic [COMP_W-1:0] brighten(logic [COMP_W-1:0] comp);
      int sum;
      sum = int'(comp) + int'(offset);
      if (sum < 0) return '0;
      if (sum > int'(COMP_MAX)) return COMP_MAX;
      return sum[COMP_W-1:0];
    endfunction

    function logic [PIXEL_W-1:0] pack_pixel(logic [INDEX_W-1:0] idx, rgb_t c);
      case (format)
        FMT_INDEXED:   return {16'b0, idx};
        FMT_RGB555:    return {9'b0, c.red[5:1], c.green[5:1], c.blue[5:1]};
        FMT_RGB565:    return {8'b0, c.red[5:1], c.green, c.blue[5:1]};
        FMT_RGB888,
        FMT_RGB888_32: return {c.red, 2'b0, c.green, 2'b0, c.blue, 2'b0};
        default:       return '0;
      endcase
    endfunction

    function lookup_t lookup_entry(logic [1:0] action, logic [INDEX_W-1:0] idx, rgb_t comps_in);
      lookup_t res;
      rgb_t    stored;
      bit      in_store;
      in_store = int'(idx) < ENTRIES;
      stored = in_store ? entries[idx] : '0;
      res.pixel = '0;
      res.comps = '0;
      case (action)
        ACT_WRITE: begin
          if (in_store) begin
            res.comps.red   = brighten(comps_in.red);
            res.comps.green = brighten(comps_in.green);
            res.comps.blue  = brighten(comps_in.blue);
            entries[idx] = res.comps;
          end
        end
        ACT_CONVERT: res.pixel = pack_pixel(idx, stored);
        ACT_READ:    res.comps = stored;
        default:     res.comps = '0;
      endcase
      return res;
    endfunction

    function void take_item(logic [1:0] action, logic [31:0] tdata);
      rgb_t c;
      c.red   = tdata[13:8];
      c.green = tdata[19:14];
      c.blue  = tdata[25:20];
      awaited.push_back(lookup_entry(action, tdata[7:0], c));
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s is 0x%0h, expected 0x%0h",
               results_seen, field, got, want);
      mismatches++;
    endtask

    task compare_result(logic [47:0] tdata);
      lookup_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report("unrequested result", 32'(tdata[23:0]), 32'd0);
      end else begin
        want = awaited.pop_front();
        if (tdata[23:0] != want.pixel) report("pixel_value", 32'(tdata[23:0]), 32'(want.pixel));
        if (tdata[29:24] != want.comps.red) report("red_out", 32'(tdata[29:24]), 32'(want.comps.red));
        if (tdata[35:30] != want.comps.green) begin
          report("green_out", 32'(tdata[35:30]), 32'(want.comps.green));
        end
        if (tdata[41:36] != want.comps.blue) begin
          report("blue_out", 32'(tdata[41:36]), 32'(want.comps.blue));
        end
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: index[7:0], red_in[13:8], green_in[19:14], blue_in[25:20], zero pad [31:26].
  logic [31:0] s_axis_tdata = '0;
  // tuser: action[1:0].
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: pixel_value[23:0], red_out[29:24], green_out[35:30], blue_out[41:36], pad [47:42].
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;

  palette_mirror mirror;
  int unsigned   cycle_count = 0;
  // When quiet is set, neither side idles; steady_offer keeps the sender from pausing.
  bit            quiet = 1'b0;
  bit            steady_offer = 1'b0;
  // A nonzero value asks the result sink to hold off for that many cycles.
  int unsigned   rx_hold_cycles = 0;

  palette_color_lookup_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // All transfers are observed in one place, at the clock edge that completes them.
  // Register writes are noted before items, and items before results, so the mirror
  // always sees events in the order the block does.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) mirror.write_register(cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) mirror.take_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) mirror.compare_result(m_axis_tdata);
    end
  end

  // Result sink. It stalls in random bursts, serves a long hold-off when asked,
  // and stays ready throughout the quiet part of the run.
  initial begin : result_sink
    int unsigned span;
    forever begin
      if (rx_hold_cycles != 0) begin
        span = rx_hold_cycles;
        rx_hold_cycles = 0;
        m_axis_tready <= 1'b0;
        repeat (span) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic rgb_t make_rgb(logic [5:0] r, logic [5:0] g, logic [5:0] b);
    rgb_t c;
    c.red = r;
    c.green = g;
    c.blue = b;
    return c;
  endfunction

  // Offers one item and waits for its transfer. Afterwards the sender may go idle
  // for a random burst; valid stays high otherwise so back-to-back items are offered.
  task automatic offer_item(logic [1:0] action, logic [7:0] idx, rgb_t c);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {6'b0, c.blue, c.green, c.red, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (!quiet && !steady_offer && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every predicted result has come back, then lets
  // the pipeline settle. The first edge makes sure the last item has been noted.
  task automatic await_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Registers change only while the block is idle: both are written back to back,
  // and valid is lowered only after the second transfer.
  task automatic apply_settings(logic [2:0] fmt, logic [7:0] offset);
    await_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_PIXEL_FORMAT;
    cfg_data_i  <= {5'b0, fmt};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_BRIGHTNESS;
    cfg_data_i  <= offset;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [5:0] random_component();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COMP_MAX;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  // Offsets favor the clamping extremes, with some out-of-range and small values.
  function automatic logic [7:0] pick_offset();
    case ($urandom_range(0, 6))
      0:       return 8'h80;
      1:       return 8'hC0;
      2:       return 8'h00;
      3:       return 8'h40;
      4:       return 8'h7F;
      5:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 16)) - 8'd8;
    endcase
  endfunction

  // Random items: mostly writes, converts and reads, a few spare actions. Half the
  // indexes come from a small window so that reads and converts hit written entries.
  task automatic offer_random_item();
    logic [1:0]  action;
    logic [7:0]  idx;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      action = ACT_WRITE;
    end else if (pick < 70) begin
      action = ACT_CONVERT;
    end else if (pick < 95) begin
      action = ACT_READ;
    end else begin
      action = ACT_UNDEFINED;
    end
    idx = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    offer_item(action, idx, make_rgb(random_component(), random_component(), random_component()));
  endtask

  initial begin : stimulus
    mirror = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Right after reset the store reads as zero and the format is indexed passthrough.
    offer_item(ACT_READ, 8'd0, make_rgb(0, 0, 0));
    offer_item(ACT_READ, 8'd255, make_rgb(63, 63, 63));
    offer_item(ACT_CONVERT, 8'd255, make_rgb(0, 0, 0));
    offer_item(ACT_WRITE, 8'd0, make_rgb(63, 0, 42));
    offer_item(ACT_WRITE, 8'd255, make_rgb(0, 63, 21));
    offer_item(ACT_READ, 8'd0, make_rgb(0, 0, 0));
    // The spare action changes nothing and reports zeros.
    offer_item(ACT_UNDEFINED, 8'd0, make_rgb(63, 63, 63));
    offer_item(ACT_CONVERT, 8'd0, make_rgb(0, 0, 0));

    // A large positive offset clamps every component at the top.
    apply_settings(FMT_RGB555, 8'h40);
    offer_item(ACT_WRITE, 8'd1, make_rgb(0, 31, 63));
    offer_item(ACT_CONVERT, 8'd1, make_rgb(0, 0, 0));
    offer_item(ACT_CONVERT, 8'd0, make_rgb(0, 0, 0));
    offer_item(ACT_CONVERT, 8'd255, make_rgb(0, 0, 0));

    // A large negative offset clamps at zero; entries already stored keep their values.
    apply_settings(FMT_RGB565, 8'hC0);
    offer_item(ACT_WRITE, 8'd2, make_rgb(63, 10, 0));
    offer_item(ACT_CONVERT, 8'd0, make_rgb(0, 0, 0));
    offer_item(ACT_CONVERT, 8'd255, make_rgb(0, 0, 0));
    offer_item(ACT_READ, 8'd1, make_rgb(0, 0, 0));

    // Offsets beyond the nominal range are added as they are.
    apply_settings(FMT_RGB888, 8'h7F);
    offer_item(ACT_WRITE, 8'd3, make_rgb(0, 0, 0));
    offer_item(ACT_CONVERT, 8'd0, make_rgb(0, 0, 0));

    apply_settings(FMT_RGB888_32, 8'h80);
    offer_item(ACT_WRITE, 8'd4, make_rgb(63, 63, 63));
    offer_item(ACT_CONVERT, 8'd255, make_rgb(0, 0, 0));

    // A spare pixel format converts to zero.
    apply_settings(FMT_UNDEFINED_HI, 8'h05);
    offer_item(ACT_CONVERT, 8'd0, make_rgb(0, 0, 0));
    offer_item(ACT_WRITE, 8'd5, make_rgb(1, 2, 60));
    offer_item(ACT_UNDEFINED, 8'd255, make_rgb(63, 63, 63));

    // Random phases walk through every pixel format code, spare ones included.
    // The last phase runs with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) begin
        apply_settings(3'($urandom_range(FMT_INDEXED, FMT_RGB888_32)), pick_offset());
        quiet = 1'b1;
      end else if (p == 5) begin
        apply_settings(FMT_UNDEFINED_LO, pick_offset());
      end else begin
        apply_settings(3'(p), pick_offset());
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // The sink holds off for a long stretch while items keep coming, so the
        // pipeline fills and the block must stall its input.
        if ((p == 1 || p == 6) && n == 20) begin
          rx_hold_cycles = 60;
          steady_offer = 1'b1;
        end
        if ((p == 1 || p == 6) && n == 50) steady_offer = 1'b0;
        // The sender pauses until every result is back, then resumes mid-phase.
        if (p == 3 && n == 60) await_results();
        offer_random_item();
      end
    end

    await_results();
    if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/plt_pkg.sv
design/plt_ram.sv
design/plt_adj.sv
design/plt_pack.sv
design/palette_color_lookup_core.sv
dv/palette_color_lookup_core_tb.sv
